>>> rtl/core/lpld_pkg.sv
// ----------------------------------------------------------------------------
// lpld_pkg: shared definitions for the loop detector
// Table depth default, field widths, register map and the command and status
// words passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package lpld_pkg;

   // Default number of table slots.
   localparam int DEFAULT_TABLE_DEPTH = 16;

   // Payload widths.
   localparam int PC_W       = 32;
   localparam int COUNT_W    = 16;
   localparam int RSP_DATA_W = 24;

   // Hit count saturates at this value.
   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   // Register file: one 32-bit register, byte address 4*index.
   localparam int                 CSR_ADDR_W             = 3;
   localparam int                 CSR_DATA_W             = 32;
   localparam logic               CSR_IDX_REPEAT_LIMIT   = 1'b0;
   localparam logic [COUNT_W-1:0] REPEAT_LIMIT_RESET     = 16'd1023;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture the incoming word
      logic lookup;   // search the table and register the match
      logic commit;   // update the table and load the output register
   } lpld_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free; // output register can take a new result this cycle
   } lpld_status_type;

endpackage

>>> rtl/core/lru_pc_loop_detector_unit.sv
// ----------------------------------------------------------------------------
// lru_pc_loop_detector_unit: recency table loop detector
// Tracks recently executed program counters with hit counts and flags a
// counter whose count rises above a programmable repeat limit.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ stream carries one program counter per word. The rsp_ stream
//   returns one word per request: loop flag, hit flag and the updated count.
//   The repeat limit is set through the csr_ port (reset value 1023); the user
//   must write it only while no request is in flight; the block does not check.
// Sequencing:
//   A request is captured when accepted; the parallel compare over all slots
//   is registered in the lookup state, and the move-to-front shift and the
//   output register are written in the update state. A new request is taken
//   in the update cycle of the previous one if the output register is free.
// Reset:
//   Synchronous. The table is emptied (fill count cleared) and the output
//   register is marked empty; no clearing pass is needed.
// Stall:
//   A result waits in the output register while rsp_tready is low; the next
//   request may be accepted and looked up meanwhile, but its update holds
//   until the waiting word is taken.
// ----------------------------------------------------------------------------
module lru_pc_loop_detector_unit
   import lpld_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PC_W-1:0]       req_tdata,   // [31:0] pc_value
   // Result stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] loop_seen, [1] was_hit,
                                              // [17:2] hit_count, [23:18] zero
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   lpld_cmd_type       cmd;
   lpld_status_type    status;
   logic [COUNT_W-1:0] repeat_limit;

   // Configuration register.
   lpld_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .repeat_limit (repeat_limit)
   );

   // Sequencing controller.
   lpld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Table and output datapath.
   lpld_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_pc       (req_tdata),
      .repeat_limit (repeat_limit),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

>>> rtl/core/lpld_csr.sv
// ----------------------------------------------------------------------------
// lpld_csr: configuration register port
// Holds the repeat limit behind a simple APB-style slave with zero wait
// states. Writes outside the register map are ignored and read as zero.
// ----------------------------------------------------------------------------
module lpld_csr
   import lpld_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [COUNT_W-1:0]    repeat_limit
);

   logic [COUNT_W-1:0] limit_ff;
   logic [COUNT_W-1:0] limit_in;
   logic               sel_limit;
   logic               wr_en;

   // Register decode on the word index.
   assign sel_limit  = (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_REPEAT_LIMIT);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Write path.
   assign limit_in = (wr_en && sel_limit) ? csr_pwdata[COUNT_W-1:0] : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= REPEAT_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // Read path.
   assign csr_prdata   = sel_limit ? {{(CSR_DATA_W-COUNT_W){1'b0}}, limit_ff} : '0;
   assign repeat_limit = limit_ff;

endmodule

>>> rtl/core/lpld_ctrl.sv
// ----------------------------------------------------------------------------
// lpld_ctrl: sequencing controller
// Walks each word through a lookup cycle and an update cycle and holds the
// update while the output register is still occupied.
// ----------------------------------------------------------------------------
module lpld_ctrl
   import lpld_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  lpld_status_type status,
   output lpld_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // A new word is taken when idle or in the cycle the table update retires.
   assign req_tready = (state_ff == ST_IDLE) ||
                       ((state_ff == ST_UPDATE) && status.out_free);
   assign accept     = req_tvalid && req_tready;

   // Commands to the datapath.
   assign cmd.load   = accept;
   assign cmd.lookup = (state_ff == ST_LOOKUP);
   assign cmd.commit = (state_ff == ST_UPDATE) && status.out_free;

   // Next state.
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            state_in = accept ? ST_LOOKUP : ST_IDLE;
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.out_free) begin
               state_in = accept ? ST_LOOKUP : ST_IDLE;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   // An update never overwrites a result that has not been taken.
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("update issued while output register is occupied");

   // Every lookup is followed by an update state.
   a_lookup_then_update: assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |=> (state_ff == ST_UPDATE))
      else $error("lookup not followed by update");

   // A word is never taken while another word is in its lookup state.
   a_load_not_lookup: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.lookup)
      else $error("word accepted during lookup");
`endif

endmodule

>>> rtl/core/lpld_datapath.sv
// ----------------------------------------------------------------------------
// lpld_datapath: recency table, match logic and output register
// The table is a row of slots kept in recency order. A lookup compares all
// valid slots at once; an update shifts the slots in front of the hit (or
// the whole used part on a miss) back by one and writes slot zero.
// ----------------------------------------------------------------------------
module lpld_datapath
   import lpld_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lpld_cmd_type          cmd,
   output lpld_status_type       status,
   input  logic [PC_W-1:0]       req_pc,
   input  logic [COUNT_W-1:0]    repeat_limit,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // Slot storage, slot zero is the most recently used.
   logic [PC_W-1:0]    entry_pc_ff    [TABLE_DEPTH];
   logic [PC_W-1:0]    entry_pc_in    [TABLE_DEPTH];
   logic [COUNT_W-1:0] entry_count_ff [TABLE_DEPTH];
   logic [COUNT_W-1:0] entry_count_in [TABLE_DEPTH];
   logic [CNT_W-1:0]   used_ff;
   logic [CNT_W-1:0]   used_in;

   // Captured word and lookup result.
   logic [PC_W-1:0]    pc_ff;
   logic [PC_W-1:0]    pc_in;
   logic               hit_ff;
   logic               hit_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   idx_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   // Output register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic               match_any;
   logic [IDX_W-1:0]   match_idx;
   logic [COUNT_W-1:0] match_count;
   logic [IDX_W-1:0]   shift_last;
   logic               loop_flag;

   // Capture the accepted word.
   assign pc_in = cmd.load ? req_pc : pc_ff;

   // Parallel compare over the valid slots. Stored counters are distinct, so
   // at most one slot matches and its index and count can be OR-collected.
   always_comb begin
      match_any   = 1'b0;
      match_idx   = '0;
      match_count = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if ((CNT_W'(i) < used_ff) && (entry_pc_ff[i] == pc_ff)) begin
            match_any   = 1'b1;
            match_idx   = match_idx | IDX_W'(i);
            match_count = match_count | entry_count_ff[i];
         end
      end
   end

   // Register the match and the new count, saturating at the maximum.
   always_comb begin
      hit_in   = hit_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      if (cmd.lookup) begin
         hit_in = match_any;
         idx_in = match_idx;
         if (!match_any) begin
            count_in = COUNT_W'(1);
         end else if (match_count == COUNT_MAX) begin
            count_in = match_count;
         end else begin
            count_in = match_count + COUNT_W'(1);
         end
      end
   end

   // Last slot that takes its predecessor: the hit slot, or on a miss the
   // first free slot (the last slot when the table is full).
   always_comb begin
      if (hit_ff) begin
         shift_last = idx_ff;
      end else if (used_ff < CNT_W'(TABLE_DEPTH)) begin
         shift_last = IDX_W'(used_ff);
      end else begin
         shift_last = IDX_W'(TABLE_DEPTH - 1);
      end
   end

   // Move-to-front update of the table.
   always_comb begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         entry_pc_in[k]    = entry_pc_ff[k];
         entry_count_in[k] = entry_count_ff[k];
      end
      if (cmd.commit) begin
         entry_pc_in[0]    = pc_ff;
         entry_count_in[0] = count_ff;
         for (int k = 1; k < TABLE_DEPTH; k++) begin
            if (IDX_W'(k) <= shift_last) begin
               entry_pc_in[k]    = entry_pc_ff[k-1];
               entry_count_in[k] = entry_count_ff[k-1];
            end
         end
      end
   end

   // Fill count grows on a miss until the table is full.
   assign used_in = (cmd.commit && !hit_ff && (used_ff < CNT_W'(TABLE_DEPTH))) ?
                    used_ff + CNT_W'(1) : used_ff;

   // Result word: loop flag, hit flag, count.
   assign loop_flag   = (count_ff > repeat_limit);
   assign rsp_data_in = cmd.commit ?
                        {{(RSP_DATA_W-COUNT_W-2){1'b0}}, count_ff, hit_ff, loop_flag} :
                        rsp_data_ff;
   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pc_ff       <= pc_in;
      hit_ff      <= hit_in;
      idx_ff      <= idx_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         entry_pc_ff[k]    <= entry_pc_in[k];
         entry_count_ff[k] <= entry_count_in[k];
      end
   end

`ifndef NO_ASSERTIONS
   // The fill count never passes the table depth.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(TABLE_DEPTH))
      else $error("fill count above table depth");

   // A hit always lies within the used part of the table.
   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && hit_ff) |-> (CNT_W'(idx_ff) < used_ff))
      else $error("hit index outside used slots");

   // The fill count never shrinks outside reset.
   a_used_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (used_ff >= $past(used_ff)))
      else $error("fill count decreased");

   // A committed update always presents a result in the next cycle.
   a_commit_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("update produced no result");
`endif

endmodule
